@@ rtl/efsd_pkg.sv @@
// ----------------------------------------------------------------------------
// efsd_pkg
// shared constants, types and codes for the earliest free server dispatch
// ----------------------------------------------------------------------------
package efsd_pkg;

   localparam int MAX_SERVERS = 10;
   localparam int TIME_BITS   = 20;
   localparam int SRV_BITS    = 4;
   localparam int WIN_BITS    = 4;
   localparam int CAP_BITS    = 12;
   localparam int SERVED_BITS = 16;
   localparam int SUM_BITS    = 32;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 12;

   localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(1);
   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(60);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_COUNT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SERVICE_CAP  = CSR_IDX_BITS'(1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                   en;
      logic [SRV_BITS-1:0]    idx;
      logic [TIME_BITS-1:0]   finish;
      logic [SERVED_BITS-1:0] served;
   } tbl_wr_type;

   typedef struct packed {
      logic                   free;   // finish time at or before arrival
      logic                   lower;  // finish time below current best
   } cmp_res_type;

   typedef struct packed {
      logic [SRV_BITS-1:0]    server_index;
      logic [TIME_BITS-1:0]   wait_time;
      logic [TIME_BITS-1:0]   finish_time;
      logic [SERVED_BITS-1:0] served_on_server;
      logic [SUM_BITS-1:0]    total_wait;
      logic [TIME_BITS-1:0]   longest_wait;
      logic [TIME_BITS-1:0]   latest_finish;
   } result_type;

endpackage

@@ rtl/efsd_srv_table.sv @@
// ----------------------------------------------------------------------------
// efsd_srv_table
// per-server finish time and served count, one read and one write port
// ----------------------------------------------------------------------------
module efsd_srv_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [efsd_pkg::SRV_BITS-1:0]       rd_idx,
   output logic [efsd_pkg::TIME_BITS-1:0]      rd_finish,
   output logic [efsd_pkg::SERVED_BITS-1:0]    rd_served,
   input  efsd_pkg::tbl_wr_type                tbl_wr
);
   import efsd_pkg::*;

   logic [TIME_BITS-1:0]   finish_ff [MAX_SERVERS];
   logic [SERVED_BITS-1:0] served_ff [MAX_SERVERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            finish_ff[i] <= '0;
            served_ff[i] <= '0;
         end
      end else if (tbl_wr.en) begin
         finish_ff[tbl_wr.idx] <= tbl_wr.finish;
         served_ff[tbl_wr.idx] <= tbl_wr.served;
      end
   end

   assign rd_finish = finish_ff[rd_idx];
   assign rd_served = served_ff[rd_idx];

endmodule

@@ rtl/efsd_cmp.sv @@
// ----------------------------------------------------------------------------
// efsd_cmp
// shared compare unit used on every scan step
// ----------------------------------------------------------------------------
module efsd_cmp (
   input  logic [efsd_pkg::TIME_BITS-1:0] finish,
   input  logic [efsd_pkg::TIME_BITS-1:0] arrival,
   input  logic [efsd_pkg::TIME_BITS-1:0] best,
   output efsd_pkg::cmp_res_type          res
);
   import efsd_pkg::*;

   always_comb begin
      res.free  = (finish <= arrival);
      res.lower = (finish < best);
   end

endmodule

@@ rtl/efsd_seq.sv @@
// ----------------------------------------------------------------------------
// efsd_seq
// sequencer: scans the servers one per cycle, then updates state and stats
// ----------------------------------------------------------------------------
module efsd_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             idle,
   input  logic [efsd_pkg::TIME_BITS-1:0]   arrival,
   input  logic [efsd_pkg::CAP_BITS-1:0]    service,
   input  logic [efsd_pkg::SRV_BITS-1:0]    last_idx,
   output logic                             res_valid,
   input  logic                             res_take,
   output efsd_pkg::result_type             result
);
   import efsd_pkg::*;

   state_type              state_ff, state_in;
   logic [TIME_BITS-1:0]   arr_ff, arr_in;
   logic [CAP_BITS-1:0]    svc_ff, svc_in;
   logic [SRV_BITS-1:0]    idx_ff, idx_in;
   logic [TIME_BITS-1:0]   best_fin_ff, best_fin_in;
   logic [SRV_BITS-1:0]    best_idx_ff, best_idx_in;
   logic [SRV_BITS-1:0]    pick_ff, pick_in;
   logic [TIME_BITS-1:0]   start_ff, start_in;
   logic [SUM_BITS-1:0]    wait_sum_ff, wait_sum_in;
   logic [TIME_BITS-1:0]   wait_max_ff, wait_max_in;
   logic [TIME_BITS-1:0]   fin_max_ff, fin_max_in;
   result_type             res_ff, res_in;

   logic [SRV_BITS-1:0]    rd_idx;
   logic [TIME_BITS-1:0]   rd_finish;
   logic [SERVED_BITS-1:0] rd_served;
   tbl_wr_type             tbl_wr;
   cmp_res_type            cmp;

   logic [TIME_BITS:0]     fin_sum;
   logic [TIME_BITS-1:0]   fin_sat;
   logic [TIME_BITS-1:0]   wait_val;
   logic [SUM_BITS:0]      wsum;
   logic [SERVED_BITS-1:0] served_new;
   logic                   take_cur;

   assign rd_idx = (state_ff == S_UPDATE) ? pick_ff : idx_ff;

   efsd_srv_table u_table (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .rd_finish (rd_finish),
      .rd_served (rd_served),
      .tbl_wr    (tbl_wr)
   );

   efsd_cmp u_cmp (
      .finish  (rd_finish),
      .arrival (arr_ff),
      .best    (best_fin_ff),
      .res     (cmp)
   );

   // update arithmetic
   always_comb begin
      fin_sum    = {1'b0, start_ff} + (TIME_BITS+1)'(svc_ff);
      fin_sat    = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
      wait_val   = start_ff - arr_ff;
      wsum       = {1'b0, wait_sum_ff} + (SUM_BITS+1)'(wait_val);
      served_new = (rd_served == '1) ? rd_served : rd_served + SERVED_BITS'(1);
      take_cur   = (idx_ff == '0) || cmp.lower;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         wait_sum_ff <= '0;
         wait_max_ff <= '0;
         fin_max_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         wait_sum_ff <= wait_sum_in;
         wait_max_ff <= wait_max_in;
         fin_max_ff  <= fin_max_in;
      end
      arr_ff      <= arr_in;
      svc_ff      <= svc_in;
      idx_ff      <= idx_in;
      best_fin_ff <= best_fin_in;
      best_idx_ff <= best_idx_in;
      pick_ff     <= pick_in;
      start_ff    <= start_in;
      res_ff      <= res_in;
   end

   always_comb begin
      state_in    = state_ff;
      arr_in      = arr_ff;
      svc_in      = svc_ff;
      idx_in      = idx_ff;
      best_fin_in = best_fin_ff;
      best_idx_in = best_idx_ff;
      pick_in     = pick_ff;
      start_in    = start_ff;
      wait_sum_in = wait_sum_ff;
      wait_max_in = wait_max_ff;
      fin_max_in  = fin_max_ff;
      res_in      = res_ff;
      tbl_wr      = '0;
      idle        = 1'b0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               arr_in   = arrival;
               svc_in   = service;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmp.free) begin
               pick_in  = idx_ff;
               start_in = arr_ff;
               state_in = S_UPDATE;
            end else begin
               if (take_cur) begin
                  best_fin_in = rd_finish;
                  best_idx_in = idx_ff;
               end
               if (idx_ff == last_idx) begin
                  // no free server: earliest finisher, lowest index on a tie
                  pick_in  = take_cur ? idx_ff : best_idx_ff;
                  start_in = take_cur ? rd_finish : best_fin_ff;
                  state_in = S_UPDATE;
               end else begin
                  idx_in = idx_ff + SRV_BITS'(1);
               end
            end
         end
         S_UPDATE: begin
            tbl_wr.en     = 1'b1;
            tbl_wr.idx    = pick_ff;
            tbl_wr.finish = fin_sat;
            tbl_wr.served = served_new;
            wait_sum_in   = wsum[SUM_BITS] ? '1 : wsum[SUM_BITS-1:0];
            wait_max_in   = (wait_val > wait_max_ff) ? wait_val : wait_max_ff;
            fin_max_in    = (fin_sat > fin_max_ff) ? fin_sat : fin_max_ff;
            res_in.server_index     = pick_ff;
            res_in.wait_time        = wait_val;
            res_in.finish_time      = fin_sat;
            res_in.served_on_server = served_new;
            res_in.total_wait       = wait_sum_in;
            res_in.longest_wait     = wait_max_in;
            res_in.latest_finish    = fin_max_in;
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result = res_ff;

endmodule

@@ rtl/earliest_free_server_dispatch_top.sv @@
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch_top
// dispatches each job to the first free server or the earliest finisher
// ----------------------------------------------------------------------------
// a job goes from the request beat through the scan of k servers (k = 1..n), the update
// and done states and the output register to rsp_valid; a new job is taken only when idle
// the scan reads one server finish time per cycle through a single compare unit
// reset: synchronous, clears all server finish times, counts and statistics,
// window_count returns to 1 and service_cap to 60
module earliest_free_server_dispatch_top (
   input  logic                               clock,
   input  logic                               reset,
   // job input channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [efsd_pkg::TIME_BITS-1:0]     req_arrival_time,
   input  logic [efsd_pkg::CAP_BITS-1:0]      req_service_time,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [efsd_pkg::SRV_BITS-1:0]      rsp_server_index,
   output logic [efsd_pkg::TIME_BITS-1:0]     rsp_wait_time,
   output logic [efsd_pkg::TIME_BITS-1:0]     rsp_finish_time,
   output logic [efsd_pkg::SERVED_BITS-1:0]   rsp_served_on_server,
   output logic [efsd_pkg::SUM_BITS-1:0]      rsp_total_wait,
   output logic [efsd_pkg::TIME_BITS-1:0]     rsp_longest_wait,
   output logic [efsd_pkg::TIME_BITS-1:0]     rsp_latest_finish,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [efsd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [efsd_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import efsd_pkg::*;

   // configuration registers
   logic [WIN_BITS-1:0] window_count_ff, window_count_in;
   logic [CAP_BITS-1:0] service_cap_ff, service_cap_in;

   // output register, decouples the sequencer from the result consumer
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   logic                seq_idle;
   logic                seq_res_valid;
   logic                seq_res_take;
   result_type          seq_result;
   logic [CAP_BITS-1:0] svc_clip;
   logic [SRV_BITS-1:0] last_idx;

   // register writes are always taken; unknown indexes fall through
   assign csr_ready = 1'b1;

   always_comb begin
      window_count_in = window_count_ff;
      service_cap_in  = service_cap_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_COUNT: window_count_in = csr_data[WIN_BITS-1:0];
            CSR_SERVICE_CAP:  service_cap_in  = csr_data[CAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // active server range: zero acts as one, too large acts as the maximum
   always_comb begin
      if (window_count_ff == '0) begin
         last_idx = '0;
      end else if (32'(window_count_ff) > 32'(MAX_SERVERS)) begin
         last_idx = SRV_BITS'(MAX_SERVERS - 1);
      end else begin
         last_idx = SRV_BITS'(window_count_ff - WIN_BITS'(1));
      end
   end

   // clip the requested service time at the job beat
   assign svc_clip = (req_service_time > service_cap_ff) ? service_cap_ff
                                                          : req_service_time;

   assign req_ready = seq_idle;

   efsd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid),
      .idle      (seq_idle),
      .arrival   (req_arrival_time),
      .service   (svc_clip),
      .last_idx  (last_idx),
      .res_valid (seq_res_valid),
      .res_take  (seq_res_take),
      .result    (seq_result)
   );

   // a finished job moves into the output register once it is empty or draining
   assign seq_res_take = seq_res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= WIN_RESET;
         service_cap_ff  <= CAP_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_count_ff <= window_count_in;
         service_cap_ff  <= service_cap_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // result beat fields
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_server_index     = rsp_data_ff.server_index;
   assign rsp_wait_time        = rsp_data_ff.wait_time;
   assign rsp_finish_time      = rsp_data_ff.finish_time;
   assign rsp_served_on_server = rsp_data_ff.served_on_server;
   assign rsp_total_wait       = rsp_data_ff.total_wait;
   assign rsp_longest_wait     = rsp_data_ff.longest_wait;
   assign rsp_latest_finish    = rsp_data_ff.latest_finish;

endmodule
